[src/i2c_master_byte_engine_unit_macros.svh]
// assertion macros for the i2c master byte engine rtl
// no dependencies; included by i2cm_engine, the module that carries assertions
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/i2cm_pkg.sv]
// shared types and constants of the i2c master byte engine
// no dependencies
package i2cm_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_BIT_DELAY   = 2'd0,
        CFG_SETUP_DELAY = 2'd1,
        CFG_ACK_LIMIT   = 2'd2
    } cfg_index_t;

    localparam int CFG_DATA_WIDTH = 16;
    localparam int LIMIT_WIDTH    = 8;
    localparam int BYTE_WIDTH     = 8;

    localparam logic [CFG_DATA_WIDTH-1:0] BIT_DELAY_RESET   = 16'd2;
    localparam logic [CFG_DATA_WIDTH-1:0] SETUP_DELAY_RESET = 16'd30;
    localparam logic [LIMIT_WIDTH-1:0]    ACK_LIMIT_RESET   = 8'd250;

    // one decoded tick as it travels from the front to the engine
    typedef struct packed {
        logic                  do_start;
        logic                  do_stop;
        logic                  do_write;
        logic                  do_read;
        logic [BYTE_WIDTH-1:0] tx_byte;
        logic                  send_ack;
        logic                  sda;
    } tick_t;

endpackage

[src/i2cm_front.sv]
// front end: accepts ticks, decodes the command and queues them
// depends on i2cm_pkg
module i2cm_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd_valid,
    input  logic [1:0]                     opcode,
    input  logic [i2cm_pkg::BYTE_WIDTH-1:0] tx_byte,
    input  logic                           send_ack,
    input  logic                           sda_sample,
    output logic                           tick_valid,
    input  logic                           tick_ready,
    output i2cm_pkg::tick_t                tick
);

    i2cm_pkg::tick_t queue_reg [2];
    i2cm_pkg::tick_t decoded;
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;

    // command decode, one-hot or none
    always_comb
    begin
        decoded.do_start = cmd_valid && (opcode == i2cm_pkg::OP_START);
        decoded.do_stop  = cmd_valid && (opcode == i2cm_pkg::OP_STOP);
        decoded.do_write = cmd_valid && (opcode == i2cm_pkg::OP_WRITE);
        decoded.do_read  = cmd_valid && (opcode == i2cm_pkg::OP_READ);
        decoded.tx_byte  = tx_byte;
        decoded.send_ack = send_ack;
        decoded.sda      = sda_sample;
    end

    assign in_ready   = (count_reg != 2'd2);
    assign tick_valid = (count_reg != 2'd0);
    assign tick       = queue_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = tick_valid && tick_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

[src/i2cm_engine.sv]
// back end: bus sequencer, configuration registers and result register
// depends on i2cm_pkg and i2c_master_byte_engine_unit_macros.svh
`include "i2c_master_byte_engine_unit_macros.svh"

module i2cm_engine
#(
    parameter int DELAY_WIDTH = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [1:0]                          cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    input  logic                                tick_valid,
    output logic                                tick_ready,
    input  i2cm_pkg::tick_t                     tick,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                scl_level,
    output logic                                sda_out_enable,
    output logic                                sda_out_level,
    output logic                                busy_res,
    output logic                                done_res,
    output logic [i2cm_pkg::BYTE_WIDTH-1:0]     rx_byte,
    output logic                                ack_timeout
);

    localparam logic [DELAY_WIDTH-1:0] DELAY_ONE = DELAY_WIDTH'(1);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_HOLD,
        PH_ST_LOW,
        PH_SP_HOLD,
        PH_SP_HIGH,
        PH_W_DATA,
        PH_W_HIGH,
        PH_W_LOW,
        PH_W_ACK,
        PH_R_SETUP,
        PH_R_LOW,
        PH_R_HIGH,
        PH_R_ACKL,
        PH_R_ACKH
    } phase_t;

    logic [i2cm_pkg::CFG_DATA_WIDTH-1:0] bit_delay_reg;
    logic [i2cm_pkg::CFG_DATA_WIDTH-1:0] setup_delay_reg;
    logic [i2cm_pkg::LIMIT_WIDTH-1:0]    ack_limit_reg;

    phase_t                          phase_reg, phase_next;
    logic [DELAY_WIDTH-1:0]          delay_reg, delay_next;
    logic [3:0]                      bit_index_reg, bit_index_next;
    logic [i2cm_pkg::BYTE_WIDTH-1:0] shift_reg, shift_next;
    logic [i2cm_pkg::LIMIT_WIDTH-1:0] poll_reg, poll_next;
    logic                            ack_choice_reg, ack_choice_next;
    logic                            scl_reg, scl_next;
    logic                            sda_en_reg, sda_en_next;
    logic                            sda_lvl_reg, sda_lvl_next;
    logic [i2cm_pkg::BYTE_WIDTH-1:0] rx_reg, rx_next;
    logic                            timeout_reg, timeout_next;
    logic                            done_reg, done_next;
    logic                            out_valid_reg, out_valid_next;

    logic                            pop;
    logic [31:0]                     bit_ext;
    logic [31:0]                     setup_ext;
    logic [DELAY_WIDTH-1:0]          bit_masked;
    logic [DELAY_WIDTH-1:0]          setup_masked;
    logic [DELAY_WIDTH-1:0]          bit_load;
    logic [DELAY_WIDTH-1:0]          setup_load;
    logic [3:0]                      bit_index_inc;
    logic [i2cm_pkg::LIMIT_WIDTH:0]  poll_inc;

    // delay loads, masked to the counter width; zero counts as one tick
    assign bit_ext      = {16'd0, bit_delay_reg};
    assign setup_ext    = {16'd0, setup_delay_reg};
    assign bit_masked   = bit_ext[DELAY_WIDTH-1:0];
    assign setup_masked = setup_ext[DELAY_WIDTH-1:0];
    assign bit_load     = (bit_masked == '0) ? DELAY_ONE : bit_masked;
    assign setup_load   = (setup_masked == '0) ? DELAY_ONE : setup_masked;

    assign bit_index_inc = bit_index_reg + 4'd1;
    assign poll_inc      = {1'b0, poll_reg} + 9'd1;

    assign tick_ready = !out_valid_reg || out_ready;
    assign pop        = tick_valid && tick_ready;

    always_comb
    begin
        phase_next      = phase_reg;
        delay_next      = delay_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        poll_next       = poll_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_en_next     = sda_en_reg;
        sda_lvl_next    = sda_lvl_reg;
        rx_next         = rx_reg;
        timeout_next    = timeout_reg;
        done_next       = done_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (pop)
        begin
            out_valid_next = 1'b1;
            done_next      = 1'b0;
            if (phase_reg == PH_IDLE)
            begin
                if (tick.do_start)
                begin
                    sda_en_next  = 1'b1;
                    sda_lvl_next = 1'b1;
                    scl_next     = 1'b1;
                    delay_next   = setup_load;
                    phase_next   = PH_ST_HOLD;
                end
                else if (tick.do_stop)
                begin
                    sda_en_next  = 1'b1;
                    scl_next     = 1'b0;
                    sda_lvl_next = 1'b0;
                    delay_next   = setup_load;
                    phase_next   = PH_SP_HOLD;
                end
                else if (tick.do_write)
                begin
                    sda_en_next    = 1'b1;
                    scl_next       = 1'b0;
                    shift_next     = tick.tx_byte;
                    bit_index_next = 4'd0;
                    timeout_next   = 1'b0;
                    sda_lvl_next   = tick.tx_byte[i2cm_pkg::BYTE_WIDTH-1];
                    delay_next     = bit_load;
                    phase_next     = PH_W_DATA;
                end
                else if (tick.do_read)
                begin
                    sda_en_next     = 1'b0;
                    ack_choice_next = tick.send_ack;
                    shift_next      = '0;
                    bit_index_next  = 4'd0;
                    delay_next      = setup_load;
                    phase_next      = PH_R_SETUP;
                end
            end
            else if (delay_reg > DELAY_ONE)
            begin
                delay_next = delay_reg - DELAY_ONE;
            end
            else
            begin
                delay_next = '0;
                case (phase_reg)
                    PH_ST_HOLD:
                    begin
                        sda_lvl_next = 1'b0;
                        delay_next   = bit_load;
                        phase_next   = PH_ST_LOW;
                    end
                    PH_ST_LOW:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    PH_SP_HOLD:
                    begin
                        scl_next   = 1'b1;
                        delay_next = bit_load;
                        phase_next = PH_SP_HIGH;
                    end
                    PH_SP_HIGH:
                    begin
                        sda_lvl_next = 1'b1;
                        phase_next   = PH_IDLE;
                        done_next    = 1'b1;
                    end
                    PH_W_DATA:
                    begin
                        scl_next   = 1'b1;
                        delay_next = bit_load;
                        phase_next = PH_W_HIGH;
                    end
                    PH_W_HIGH:
                    begin
                        scl_next   = 1'b0;
                        delay_next = bit_load;
                        phase_next = PH_W_LOW;
                    end
                    PH_W_LOW:
                    begin
                        shift_next     = {shift_reg[i2cm_pkg::BYTE_WIDTH-2:0], 1'b0};
                        bit_index_next = bit_index_inc;
                        delay_next     = bit_load;
                        if (bit_index_inc[3])
                        begin
                            sda_en_next  = 1'b0;
                            sda_lvl_next = 1'b1;
                            scl_next     = 1'b1;
                            poll_next    = '0;
                            phase_next   = PH_W_ACK;
                        end
                        else
                        begin
                            sda_lvl_next = shift_reg[i2cm_pkg::BYTE_WIDTH-2];
                            phase_next   = PH_W_DATA;
                        end
                    end
                    PH_W_ACK:
                    begin
                        if (!tick.sda)
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                        else if (poll_inc > {1'b0, ack_limit_reg})
                        begin
                            // poll limit exceeded: flag it and run a stop
                            timeout_next = 1'b1;
                            sda_en_next  = 1'b1;
                            scl_next     = 1'b0;
                            sda_lvl_next = 1'b0;
                            delay_next   = setup_load;
                            phase_next   = PH_SP_HOLD;
                        end
                        else
                        begin
                            poll_next  = poll_inc[i2cm_pkg::LIMIT_WIDTH-1:0];
                            delay_next = bit_load;
                        end
                    end
                    PH_R_SETUP:
                    begin
                        scl_next   = 1'b0;
                        delay_next = bit_load;
                        phase_next = PH_R_LOW;
                    end
                    PH_R_LOW:
                    begin
                        scl_next   = 1'b1;
                        shift_next = {shift_reg[i2cm_pkg::BYTE_WIDTH-2:0], tick.sda};
                        delay_next = bit_load;
                        phase_next = PH_R_HIGH;
                    end
                    PH_R_HIGH:
                    begin
                        bit_index_next = bit_index_inc;
                        scl_next       = 1'b0;
                        delay_next     = bit_load;
                        if (bit_index_inc[3])
                        begin
                            rx_next      = shift_reg;
                            sda_en_next  = 1'b1;
                            sda_lvl_next = !ack_choice_reg;
                            phase_next   = PH_R_ACKL;
                        end
                        else
                        begin
                            phase_next = PH_R_LOW;
                        end
                    end
                    PH_R_ACKL:
                    begin
                        scl_next   = 1'b1;
                        delay_next = bit_load;
                        phase_next = PH_R_ACKH;
                    end
                    PH_R_ACKH:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_delay_reg   <= i2cm_pkg::BIT_DELAY_RESET;
            setup_delay_reg <= i2cm_pkg::SETUP_DELAY_RESET;
            ack_limit_reg   <= i2cm_pkg::ACK_LIMIT_RESET;
            phase_reg       <= PH_IDLE;
            delay_reg       <= '0;
            bit_index_reg   <= 4'd0;
            shift_reg       <= '0;
            poll_reg        <= '0;
            ack_choice_reg  <= 1'b0;
            scl_reg         <= 1'b1;
            sda_en_reg      <= 1'b1;
            sda_lvl_reg     <= 1'b1;
            rx_reg          <= '0;
            timeout_reg     <= 1'b0;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    i2cm_pkg::CFG_BIT_DELAY:   bit_delay_reg   <= cfg_data;
                    i2cm_pkg::CFG_SETUP_DELAY: setup_delay_reg <= cfg_data;
                    i2cm_pkg::CFG_ACK_LIMIT:
                        ack_limit_reg <= cfg_data[i2cm_pkg::LIMIT_WIDTH-1:0];
                    default:
                    begin
                    end
                endcase
            end
            phase_reg      <= phase_next;
            delay_reg      <= delay_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            poll_reg       <= poll_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_en_reg     <= sda_en_next;
            sda_lvl_reg    <= sda_lvl_next;
            rx_reg         <= rx_next;
            timeout_reg    <= timeout_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign scl_level      = scl_reg;
    assign sda_out_enable = sda_en_reg;
    assign sda_out_level  = sda_lvl_reg;
    assign busy_res       = (phase_reg != PH_IDLE);
    assign done_res       = done_reg;
    assign rx_byte        = rx_reg;
    assign ack_timeout    = timeout_reg;

    // a finished command always leaves the sequencer idle
    `I2CM_ASSERT_NOW(a_done_idle, clk, rst_n, done_reg, phase_reg == PH_IDLE, "done while busy")
    // the timeout flag only rises together with the stop it forces
    `I2CM_ASSERT_NOW(a_timeout_stop, clk, rst_n, $rose(timeout_reg), phase_reg == PH_SP_HOLD, "timeout without stop")
    // without a tick taken the sequencer does not move
    `I2CM_ASSERT_NEXT(a_hold_no_tick, clk, rst_n, !pop, $stable(phase_reg) && $stable(delay_reg), "sequencer moved without a tick")

endmodule

[src/i2c_master_byte_engine_unit.sv]
// top level of the i2c master byte engine: queued tick front end and bus engine
// depends on i2cm_pkg, i2cm_front and i2cm_engine
//
// usage
//   input channel (in_valid/in_ready): one transaction per timing tick, carrying an
//   optional command (cmd_valid, opcode, tx_byte, send_ack) and the sampled sda level
//   output channel (out_valid/out_ready): exactly one result transaction per input
//   transaction, in order: scl and sda drive, busy, done pulse, rx_byte, ack_timeout
//   config port: cfg_write_en writes cfg_data into register cfg_index at the clock
//   edge (0 bit delay, 1 setup delay, 2 ack poll limit); write only while idle
// latency and throughput
//   a tick's result sits in the output register one cycle after the tick is accepted
//   (queue write, then one sequencer step) and can be taken at the following edge
//   one tick per cycle sustained; the sequencer updates once per tick and holds a
//   single result register, so out_ready low for one cycle costs one cycle
// stalls
//   while out_ready is low the result register holds and the sequencer freezes; the
//   queue still takes up to two more ticks before in_ready drops
// reset
//   rst_n clears the queue, restores the register defaults (2, 30, 250) and puts the
//   bus in its idle state with scl high and sda driven high; no clearing pass
module i2c_master_byte_engine_unit
#(
    parameter int DELAY_WIDTH = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_write_en,
    input  logic [1:0]                          cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    // tick input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd_valid,
    input  logic [1:0]                          opcode,
    input  logic [i2cm_pkg::BYTE_WIDTH-1:0]     tx_byte,
    input  logic                                send_ack,
    input  logic                                sda_sample,
    // result output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                scl_level,
    output logic                                sda_out_enable,
    output logic                                sda_out_level,
    output logic                                busy_res,
    output logic                                done_res,
    output logic [i2cm_pkg::BYTE_WIDTH-1:0]     rx_byte,
    output logic                                ack_timeout
);

    // decoded ticks between the front end queue and the engine
    logic            tick_valid;
    logic            tick_ready;
    i2cm_pkg::tick_t tick;

    // front end: decode the command and buffer the transaction
    i2cm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd_valid  (cmd_valid),
        .opcode     (opcode),
        .tx_byte    (tx_byte),
        .send_ack   (send_ack),
        .sda_sample (sda_sample),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick)
    );

    // back end: timed scl/sda sequencer with the result register
    i2cm_engine #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_engine
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .tick_valid     (tick_valid),
        .tick_ready     (tick_ready),
        .tick           (tick),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .scl_level      (scl_level),
        .sda_out_enable (sda_out_enable),
        .sda_out_level  (sda_out_level),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .rx_byte        (rx_byte),
        .ack_timeout    (ack_timeout)
    );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for i2c_master_byte_engine_unit: bus sequencing, ack polling,
// read sampling, delay registers; predicts every result tick and checks it in order
// depends on i2cm_pkg and the rtl of i2c_master_byte_engine_unit
module tb_top;

    localparam int          DELAY_W         = 16;
    localparam int          MAX_IDLE        = 12;
    localparam int          SETTLE_CYCLES   = 6;
    localparam int          CYCLE_LIMIT     = 2000000;
    localparam int          RANDOM_PHASES   = 2;
    localparam int          TICKS_PER_PHASE = 50;
    localparam int          MAX_REPORTS     = 10;
    localparam int          NEVER_ACK       = 100000;
    localparam logic [1:0]  CFG_SPARE_INDEX = 2'd3;

    // where the bus sequencer stands between ticks
    typedef enum logic [3:0] {
        BUS_IDLE,
        BUS_START_HOLD,
        BUS_START_LOW,
        BUS_STOP_HOLD,
        BUS_STOP_HIGH,
        BUS_WR_DATA,
        BUS_WR_HIGH,
        BUS_WR_LOW,
        BUS_WR_ACK,
        BUS_RD_SETUP,
        BUS_RD_LOW,
        BUS_RD_HIGH,
        BUS_RD_ACK_LOW,
        BUS_RD_ACK_HIGH
    } bus_phase_t;

    // one timing tick as offered on the input channel
    typedef struct packed {
        logic                            cmd;
        i2cm_pkg::opcode_t               op;
        logic [i2cm_pkg::BYTE_WIDTH-1:0] tx;
        logic                            ack;
        logic                            sda;
    } tick_item_t;

    // line levels and status after one tick
    typedef struct packed {
        logic                            scl;
        logic                            sda_en;
        logic                            sda_lvl;
        logic                            busy;
        logic                            done;
        logic [i2cm_pkg::BYTE_WIDTH-1:0] rx;
        logic                            tmo;
    } bus_result_t;

    // shadow of the sequencer state
    typedef struct {
        bus_phase_t                      ph;
        int unsigned                     ticks_left;
        int unsigned                     bits_done;
        logic [i2cm_pkg::BYTE_WIDTH-1:0] shreg;
        int unsigned                     polls;
        logic                            ack_pick;
        logic                            scl;
        logic                            sda_en;
        logic                            sda_lvl;
        logic [i2cm_pkg::BYTE_WIDTH-1:0] rx;
        logic                            tmo;
    } bus_state_t;

    // clock, reset and every block input start at known values
    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                cfg_write_en = 1'b0;
    logic [1:0]                          cfg_index    = i2cm_pkg::CFG_BIT_DELAY;
    logic [i2cm_pkg::CFG_DATA_WIDTH-1:0] cfg_data     = '0;
    logic                                in_valid     = 1'b0;
    logic                                in_ready;
    logic                                cmd_valid    = 1'b0;
    logic [1:0]                          opcode       = i2cm_pkg::OP_START;
    logic [i2cm_pkg::BYTE_WIDTH-1:0]     tx_byte      = '0;
    logic                                send_ack     = 1'b0;
    logic                                sda_sample   = 1'b1;
    logic                                out_valid;
    logic                                out_ready    = 1'b0;
    logic                                scl_level;
    logic                                sda_out_enable;
    logic                                sda_out_level;
    logic                                busy_res;
    logic                                done_res;
    logic [i2cm_pkg::BYTE_WIDTH-1:0]     rx_byte;
    logic                                ack_timeout;

    // predictor state and its copy of the registers
    bus_state_t                          bus;
    logic [i2cm_pkg::CFG_DATA_WIDTH-1:0] bit_ticks_cfg;
    logic [i2cm_pkg::CFG_DATA_WIDTH-1:0] setup_ticks_cfg;
    logic [i2cm_pkg::LIMIT_WIDTH-1:0]    poll_limit_cfg;

    // predicted line states waiting for their result transaction
    bus_result_t               expected_lines[$];

    int                        error_count    = 0;
    int                        results_seen   = 0;
    int                        ticks_sent     = 0;
    int                        cycle_count    = 0;
    int                        noise_pct      = 0;
    logic                      send_idle      = 1'b1;
    logic                      recv_idle      = 1'b1;

    i2c_master_byte_engine_unit #(
        .DELAY_WIDTH(DELAY_W)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd_valid      (cmd_valid),
        .opcode         (opcode),
        .tx_byte        (tx_byte),
        .send_ack       (send_ack),
        .sda_sample     (sda_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .scl_level      (scl_level),
        .sda_out_enable (sda_out_enable),
        .sda_out_level  (sda_out_level),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .rx_byte        (rx_byte),
        .ack_timeout    (ack_timeout)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // bus predictor
    // ------------------------------------------------------------------

    // a zero delay register still holds the lines for one tick
    function automatic int unsigned seg_len(logic [i2cm_pkg::CFG_DATA_WIDTH-1:0] ticks);
        return (ticks == '0) ? 1 : int'(ticks);
    endfunction

    // stop: scl low, sda low, then long hold before scl rises
    function automatic void enter_stop();
        bus.sda_en     = 1'b1;
        bus.scl        = 1'b0;
        bus.sda_lvl    = 1'b0;
        bus.ticks_left = seg_len(setup_ticks_cfg);
        bus.ph         = BUS_STOP_HOLD;
    endfunction

    // put the current msb on sda while scl is low
    function automatic void drive_bit();
        bus.sda_lvl    = bus.shreg[7];
        bus.ticks_left = seg_len(bit_ticks_cfg);
        bus.ph         = BUS_WR_DATA;
    endfunction

    // advances the shadow sequencer by one tick and returns the lines it then drives
    function automatic bus_result_t advance_bus(tick_item_t t);
        bus_result_t r;
        logic        fin;
        int unsigned next_polls;
        fin = 1'b0;
        if (bus.ph == BUS_IDLE)
        begin
            // commands only land while idle
            if (t.cmd)
            begin
                case (t.op)
                    i2cm_pkg::OP_START:
                    begin
                        bus.sda_en     = 1'b1;
                        bus.sda_lvl    = 1'b1;
                        bus.scl        = 1'b1;
                        bus.ticks_left = seg_len(setup_ticks_cfg);
                        bus.ph         = BUS_START_HOLD;
                    end
                    i2cm_pkg::OP_STOP:
                        enter_stop();
                    i2cm_pkg::OP_WRITE:
                    begin
                        bus.sda_en    = 1'b1;
                        bus.scl       = 1'b0;
                        bus.shreg     = t.tx;
                        bus.bits_done = 0;
                        bus.tmo       = 1'b0;
                        drive_bit();
                    end
                    default:
                    begin
                        bus.sda_en     = 1'b0;
                        bus.ack_pick   = t.ack;
                        bus.shreg      = '0;
                        bus.bits_done  = 0;
                        bus.ticks_left = seg_len(setup_ticks_cfg);
                        bus.ph         = BUS_RD_SETUP;
                    end
                endcase
            end
        end
        else if (bus.ticks_left > 1)
        begin
            bus.ticks_left--;
        end
        else
        begin
            // segment expires: take the next step of the sequence
            bus.ticks_left = 0;
            case (bus.ph)
                BUS_START_HOLD:
                begin
                    bus.sda_lvl    = 1'b0;
                    bus.ticks_left = seg_len(bit_ticks_cfg);
                    bus.ph         = BUS_START_LOW;
                end
                BUS_START_LOW:
                begin
                    bus.scl = 1'b0;
                    bus.ph  = BUS_IDLE;
                    fin     = 1'b1;
                end
                BUS_STOP_HOLD:
                begin
                    bus.scl        = 1'b1;
                    bus.ticks_left = seg_len(bit_ticks_cfg);
                    bus.ph         = BUS_STOP_HIGH;
                end
                BUS_STOP_HIGH:
                begin
                    bus.sda_lvl = 1'b1;
                    bus.ph      = BUS_IDLE;
                    fin         = 1'b1;
                end
                BUS_WR_DATA:
                begin
                    bus.scl        = 1'b1;
                    bus.ticks_left = seg_len(bit_ticks_cfg);
                    bus.ph         = BUS_WR_HIGH;
                end
                BUS_WR_HIGH:
                begin
                    bus.scl        = 1'b0;
                    bus.ticks_left = seg_len(bit_ticks_cfg);
                    bus.ph         = BUS_WR_LOW;
                end
                BUS_WR_LOW:
                begin
                    bus.shreg     = {bus.shreg[6:0], 1'b0};
                    bus.bits_done = (bus.bits_done + 1) & 4'hF;
                    if (bus.bits_done >= 8)
                    begin
                        // release sda and raise scl for the ack slot
                        bus.sda_en     = 1'b0;
                        bus.sda_lvl    = 1'b1;
                        bus.scl        = 1'b1;
                        bus.polls      = 0;
                        bus.ticks_left = seg_len(bit_ticks_cfg);
                        bus.ph         = BUS_WR_ACK;
                    end
                    else
                    begin
                        drive_bit();
                    end
                end
                BUS_WR_ACK:
                begin
                    if (t.sda == 1'b0)
                    begin
                        bus.scl = 1'b0;
                        bus.ph  = BUS_IDLE;
                        fin     = 1'b1;
                    end
                    else
                    begin
                        next_polls = bus.polls + 1;
                        if (next_polls > poll_limit_cfg)
                        begin
                            bus.tmo = 1'b1;
                            enter_stop();
                        end
                        else
                        begin
                            bus.polls      = next_polls & 8'hFF;
                            bus.ticks_left = seg_len(bit_ticks_cfg);
                        end
                    end
                end
                BUS_RD_SETUP:
                begin
                    bus.scl        = 1'b0;
                    bus.ticks_left = seg_len(bit_ticks_cfg);
                    bus.ph         = BUS_RD_LOW;
                end
                BUS_RD_LOW:
                begin
                    // sample on the rising scl edge
                    bus.scl        = 1'b1;
                    bus.shreg      = {bus.shreg[6:0], t.sda};
                    bus.ticks_left = seg_len(bit_ticks_cfg);
                    bus.ph         = BUS_RD_HIGH;
                end
                BUS_RD_HIGH:
                begin
                    bus.bits_done  = (bus.bits_done + 1) & 4'hF;
                    bus.scl        = 1'b0;
                    bus.ticks_left = seg_len(bit_ticks_cfg);
                    if (bus.bits_done >= 8)
                    begin
                        bus.rx      = bus.shreg;
                        bus.sda_en  = 1'b1;
                        bus.sda_lvl = ~bus.ack_pick;
                        bus.ph      = BUS_RD_ACK_LOW;
                    end
                    else
                    begin
                        bus.ph = BUS_RD_LOW;
                    end
                end
                BUS_RD_ACK_LOW:
                begin
                    bus.scl        = 1'b1;
                    bus.ticks_left = seg_len(bit_ticks_cfg);
                    bus.ph         = BUS_RD_ACK_HIGH;
                end
                BUS_RD_ACK_HIGH:
                begin
                    bus.scl = 1'b0;
                    bus.ph  = BUS_IDLE;
                    fin     = 1'b1;
                end
                default:
                    bus.ph = BUS_IDLE;
            endcase
        end
        r.scl     = bus.scl;
        r.sda_en  = bus.sda_en;
        r.sda_lvl = bus.sda_lvl;
        r.busy    = (bus.ph != BUS_IDLE);
        r.done    = fin;
        r.rx      = bus.rx;
        r.tmo     = bus.tmo;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offers one tick, holds it until the transaction happens, then predicts it;
    // called and returning on a rising edge
    task automatic send_tick(tick_item_t t);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd_valid  <= t.cmd;
        opcode     <= t.op;
        tx_byte    <= t.tx;
        send_ack   <= t.ack;
        sda_sample <= t.sda;
        do
            @(posedge clk);
        while (!in_ready);
        expected_lines.push_back(advance_bus(t));
        ticks_sent++;
    endtask

    // issues one command on an idle engine and keeps ticking until it is idle again;
    // read bits come from rd_bits msb first, the ack slot sees sda high for
    // ack_wait polls before it is pulled low
    task automatic run_cmd(i2cm_pkg::opcode_t op, logic [7:0] tx, logic ack,
                           logic [7:0] rd_bits, int ack_wait);
        tick_item_t t;
        t.cmd = 1'b1;
        t.op  = op;
        t.tx  = tx;
        t.ack = ack;
        t.sda = 1'($urandom_range(0, 1));
        send_tick(t);
        while (bus.ph != BUS_IDLE)
        begin
            // commands offered while busy must be dropped
            t.cmd = ($urandom_range(0, 99) < noise_pct);
            t.op  = i2cm_pkg::opcode_t'($urandom_range(0, 3));
            t.tx  = 8'($urandom_range(0, 255));
            t.ack = 1'($urandom_range(0, 1));
            case (bus.ph)
                BUS_RD_LOW: t.sda = rd_bits[7 - bus.bits_done];
                BUS_WR_ACK: t.sda = (bus.polls < ack_wait);
                default:    t.sda = 1'($urandom_range(0, 1));
            endcase
            send_tick(t);
        end
    endtask

    // ticks with no command while the engine is idle
    task automatic idle_ticks(int count);
        tick_item_t t;
        repeat (count)
        begin
            t.cmd = 1'b0;
            t.op  = i2cm_pkg::opcode_t'($urandom_range(0, 3));
            t.tx  = 8'($urandom_range(0, 255));
            t.ack = 1'($urandom_range(0, 1));
            t.sda = 1'($urandom_range(0, 1));
            send_tick(t);
        end
    endtask

    // mostly quick acks, some near the limit, some never
    function automatic int pick_ack_wait();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(0, 2);
        else if (roll < 85)
            return $urandom_range(0, int'(poll_limit_cfg) + 1);
        else
            return NEVER_ACK;
    endfunction

    // stop offering ticks and let every predicted result come out
    task automatic quiesce();
        in_valid <= 1'b0;
        while (expected_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; only called with the engine drained
    task automatic write_reg(logic [1:0] idx, logic [i2cm_pkg::CFG_DATA_WIDTH-1:0] data);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            i2cm_pkg::CFG_BIT_DELAY:   bit_ticks_cfg   = data;
            i2cm_pkg::CFG_SETUP_DELAY: setup_ticks_cfg = data;
            i2cm_pkg::CFG_ACK_LIMIT:   poll_limit_cfg  = data[i2cm_pkg::LIMIT_WIDTH-1:0];
            default:                   ;
        endcase
    endtask

    task automatic load_settings(logic [i2cm_pkg::CFG_DATA_WIDTH-1:0] bit_ticks,
                                 logic [i2cm_pkg::CFG_DATA_WIDTH-1:0] setup_ticks,
                                 logic [i2cm_pkg::LIMIT_WIDTH-1:0] limit);
        quiesce();
        write_reg(i2cm_pkg::CFG_BIT_DELAY, bit_ticks);
        write_reg(i2cm_pkg::CFG_SETUP_DELAY, setup_ticks);
        write_reg(i2cm_pkg::CFG_ACK_LIMIT, {8'h00, limit});
    endtask

    // ------------------------------------------------------------------
    // output side: random back-pressure and in-order checking
    // ------------------------------------------------------------------

    function automatic void compare_field(string fname, logic [7:0] want, logic [7:0] seen);
        if (seen !== want)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("result %0d field %s: expected %0h, actual %0h",
                         results_seen, fname, want, seen);
        end
    endfunction

    initial
    begin : result_checker
        int          stall;
        bus_result_t want;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_lines.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("result %0d arrived with nothing predicted", results_seen);
                end
                else
                begin
                    want = expected_lines.pop_front();
                    compare_field("scl_level", 8'(want.scl), 8'(scl_level));
                    compare_field("sda_out_enable", 8'(want.sda_en), 8'(sda_out_enable));
                    compare_field("sda_out_level", 8'(want.sda_lvl), 8'(sda_out_level));
                    compare_field("busy_res", 8'(want.busy), 8'(busy_res));
                    compare_field("done_res", 8'(want.done), 8'(done_res));
                    compare_field("rx_byte", want.rx, rx_byte);
                    compare_field("ack_timeout", 8'(want.tmo), 8'(ack_timeout));
                end
                results_seen++;
                stall = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
            end
            // one assignment per edge keeps out_ready free of ordering races
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset register values: a full transfer with extreme bytes, ack and nack reads,
    // and commands offered while busy
    task automatic test_bus_basics();
        noise_pct = 30;
        idle_ticks(3);
        run_cmd(i2cm_pkg::OP_START, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(i2cm_pkg::OP_WRITE, 8'hFF, 1'b0, 8'h00, 0);
        run_cmd(i2cm_pkg::OP_WRITE, 8'h00, 1'b1, 8'hFF, 3);
        run_cmd(i2cm_pkg::OP_READ, 8'h00, 1'b1, 8'hFF, 0);
        run_cmd(i2cm_pkg::OP_READ, 8'hFF, 1'b0, 8'h00, 0);
        run_cmd(i2cm_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 0);
        idle_ticks(2);
    endtask

    // ack polling: timeout at the reset limit, flag kept by read and cleared by write,
    // a limit of zero, the largest limit, and a limit written with upper junk bits
    task automatic test_ack_timeout();
        noise_pct = 10;
        run_cmd(i2cm_pkg::OP_START, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(i2cm_pkg::OP_WRITE, 8'h5A, 1'b0, 8'h00, NEVER_ACK);
        run_cmd(i2cm_pkg::OP_START, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(i2cm_pkg::OP_READ, 8'h00, 1'b0, 8'hC3, 0);
        run_cmd(i2cm_pkg::OP_WRITE, 8'h3C, 1'b0, 8'h00, 1);
        run_cmd(i2cm_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 0);

        load_settings(16'd1, 16'd2, 8'd0);
        run_cmd(i2cm_pkg::OP_WRITE, 8'hA5, 1'b0, 8'h00, NEVER_ACK);
        run_cmd(i2cm_pkg::OP_WRITE, 8'h96, 1'b0, 8'h00, 0);

        load_settings(16'd1, 16'd1, 8'd255);
        run_cmd(i2cm_pkg::OP_WRITE, 8'h81, 1'b0, 8'h00, NEVER_ACK);

        // only the low byte of the data lands in the limit register
        quiesce();
        write_reg(i2cm_pkg::CFG_ACK_LIMIT, 16'hFF03);
        run_cmd(i2cm_pkg::OP_WRITE, 8'h7E, 1'b0, 8'h00, 3);
        run_cmd(i2cm_pkg::OP_WRITE, 8'hE7, 1'b0, 8'h00, 4);
    endtask

    // zero delays behave as one tick, a write to the unused index changes nothing,
    // and long delays run a start and a stop with no idling
    task automatic test_delay_corners();
        noise_pct = 20;
        quiesce();
        write_reg(i2cm_pkg::CFG_BIT_DELAY, 16'h0000);
        write_reg(i2cm_pkg::CFG_SETUP_DELAY, 16'h0000);
        write_reg(CFG_SPARE_INDEX, 16'hFFFF);
        run_cmd(i2cm_pkg::OP_START, 8'h00, 1'b0, 8'h00, 0);
        run_cmd(i2cm_pkg::OP_WRITE, 8'h81, 1'b0, 8'h00, 0);
        run_cmd(i2cm_pkg::OP_READ, 8'h00, 1'b1, 8'h7E, 0);
        run_cmd(i2cm_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 0);

        send_idle = 1'b0;
        recv_idle = 1'b0;
        noise_pct = 1;
        load_settings(16'd1, 16'd24, 8'd2);
        run_cmd(i2cm_pkg::OP_START, 8'h00, 1'b0, 8'h00, 0);
        load_settings(16'd24, 16'd1, 8'd2);
        run_cmd(i2cm_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 0);
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // mostly well-formed transfers (start, a few byte transactions, stop) with random
    // content, the rest lone commands in any order and idle ticks
    task automatic test_random_traffic();
        int          p;
        int          k;
        int          nbytes;
        int          stop_at;
        int          roll;
        logic [15:0] limit_pick;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                limit_pick = 16'($urandom_range(0, 4));
            else if (roll < 80)
                limit_pick = 16'($urandom_range(5, 30));
            else
                limit_pick = 16'($urandom_range(200, 255));
            load_settings(16'($urandom_range(1, 3)), 16'($urandom_range(1, 8)),
                          limit_pick[7:0]);
            noise_pct = $urandom_range(0, 20);
            stop_at   = ticks_sent + TICKS_PER_PHASE;
            while (ticks_sent < stop_at)
            begin
                // switch between idling and back-to-back stretches now and then
                if ($urandom_range(0, 5) == 0)
                    send_idle = ~send_idle;
                if ($urandom_range(0, 5) == 0)
                    recv_idle = ~recv_idle;
                roll = $urandom_range(0, 99);
                if (roll < 85)
                begin
                    nbytes = $urandom_range(1, 4);
                    run_cmd(i2cm_pkg::OP_START, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 0);
                    for (k = 0; k < nbytes; k++)
                    begin
                        if ($urandom_range(0, 1))
                            run_cmd(i2cm_pkg::OP_WRITE, 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                    pick_ack_wait());
                        else
                            run_cmd(i2cm_pkg::OP_READ, 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                    0);
                    end
                    run_cmd(i2cm_pkg::OP_STOP, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 0);
                end
                else if (roll < 95)
                begin
                    run_cmd(i2cm_pkg::opcode_t'($urandom_range(0, 3)),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            8'($urandom_range(0, 255)), pick_ack_wait());
                end
                else
                begin
                    idle_ticks($urandom_range(1, 6));
                end
            end
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        // shadow state matches the block right after reset
        bus = '{ph: BUS_IDLE, ticks_left: 0, bits_done: 0, shreg: 8'h00, polls: 0,
                ack_pick: 1'b0, scl: 1'b1, sda_en: 1'b1, sda_lvl: 1'b1, rx: 8'h00,
                tmo: 1'b0};
        bit_ticks_cfg   = i2cm_pkg::BIT_DELAY_RESET;
        setup_ticks_cfg = i2cm_pkg::SETUP_DELAY_RESET;
        poll_limit_cfg  = i2cm_pkg::ACK_LIMIT_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bus_basics();
        test_ack_timeout();
        test_delay_corners();
        test_random_traffic();

        // every predicted transaction must come out, then nothing more may follow
        quiesce();
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // hung handshake or missing results
    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/i2cm_pkg.sv
src/i2cm_front.sv
src/i2cm_engine.sv
src/i2c_master_byte_engine_unit.sv
verif/tb_top.sv
